// ----- rtl/cbst_pkg.sv -----
// ----------------------------------------------------------------------------
// cbst_pkg
// Shared widths, register indexes and record types of the stroke tessellator.
// ----------------------------------------------------------------------------
package cbst_pkg;

   localparam int COORD_W   = 16;
   localparam int SEG_W     = 5;
   localparam int WIDTH_W   = 12;
   localparam int COLOR_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int WEIGHT_W  = 15;
   localparam int ACC_W     = 33;

   localparam logic [CSR_IDX_W-1:0] CSR_STROKE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_COLOR   = 2'd1;

   localparam logic [WIDTH_W-1:0] STROKE_WIDTH_RESET = 12'd48;
   localparam logic [COLOR_W-1:0] FILL_COLOR_RESET   = 32'd0;

   localparam logic signed [17:0] COORD_MAX = 18'sd32767;
   localparam logic signed [17:0] COORD_MIN = -18'sd32768;

   typedef logic signed [COORD_W-1:0] coord_type;

   // one chord between two rounded curve points
   typedef struct packed {
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
      logic      draw;  // endpoints differ
      logic      tail;  // final chord of the curve
   } chord_type;

   function automatic coord_type sat_coord(input logic signed [17:0] v);
      coord_type r;
      if (v > COORD_MAX) r = 16'sh7FFF;
      else if (v < COORD_MIN) r = -16'sh8000;
      else r = v[15:0];
      return r;
   endfunction

endpackage

// ----- rtl/cbst_chord_queue.sv -----
// ----------------------------------------------------------------------------
// cbst_chord_queue
// Four-entry queue of chord records between the front and back parts.
// ----------------------------------------------------------------------------
module cbst_chord_queue import cbst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      cq_push,
   input  chord_type cq_wdata,
   output logic      cq_full,
   input  logic      cq_pop,
   output chord_type cq_rdata,
   output logic      cq_empty
);

   chord_type  mem [4];
   logic [1:0] wr_ff;
   logic [1:0] rd_ff;
   logic [2:0] cnt_ff;

   assign cq_full  = (cnt_ff == 3'd4);
   assign cq_empty = (cnt_ff == 3'd0);
   assign cq_rdata = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (cq_push && !cq_full) begin
         mem[wr_ff] <= cq_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (cq_push && !cq_full) wr_ff <= wr_ff + 2'd1;
         if (cq_pop && !cq_empty) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'((cq_push && !cq_full) ? 1 : 0)
                          - 3'((cq_pop && !cq_empty) ? 1 : 0);
      end
   end

endmodule

// ----- rtl/cbst_front.sv -----
// ----------------------------------------------------------------------------
// cbst_front
// Accepts a curve, evaluates its points one coordinate at a time and queues
// the chords, marking the final one; degenerate ones go only as the final one.
// ----------------------------------------------------------------------------
module cbst_front import cbst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  coord_type        req_p0_x,
   input  coord_type        req_p0_y,
   input  coord_type        req_c1_x,
   input  coord_type        req_c1_y,
   input  coord_type        req_c2_x,
   input  coord_type        req_c2_y,
   input  coord_type        req_p3_x,
   input  coord_type        req_p3_y,
   input  logic [SEG_W-1:0] req_segments,
   output logic             cq_push,
   output chord_type        cq_wdata,
   input  logic             cq_full
);

   typedef enum logic [3:0] {
      F_IDLE, F_DEN_A, F_DEN_B, F_W_A, F_W_B, F_W_C, F_W_D, F_W_E, F_W_F,
      F_MAC, F_PREP, F_DIV, F_STORE, F_PUSH
   } state_type;

   state_type           state_ff;
   logic [SEG_W-1:0]    n_ff, i_ff;
   logic                ax_ff;
   logic [1:0]          k_ff;
   logic [3:0]          j_ff;
   coord_type           ctl_x_ff [4];
   coord_type           ctl_y_ff [4];
   logic [9:0]          sq_ff, u2_ff, i2_ff;
   logic [WEIGHT_W-1:0] den_ff;
   logic [WEIGHT_W-1:0] w_ff [4];
   logic signed [ACC_W-1:0] acc_ff;
   logic                neg_ff;
   logic [15:0]         rem_ff, dq_ff;
   coord_type           cur_x_ff, cur_y_ff, prev_x_ff, prev_y_ff;

   logic [SEG_W-1:0]    u;
   logic [14:0]         ma;
   logic [4:0]          mb;
   logic [19:0]         mp;
   logic [15:0]         mp3;
   coord_type           ctl;
   logic signed [31:0]  prod;
   logic signed [ACC_W-1:0] acc_in, mag;
   logic [32:0]         dvd;
   logic [16:0]         r2;
   logic [15:0]         dvs;
   logic                ge;
   coord_type           res;
   logic                draw, tail;

   assign u = n_ff - i_ff;

   // small multiplier for the Bernstein weights and n cubed
   always_comb begin
      unique case (state_ff)
         F_DEN_A: begin ma = {10'd0, n_ff};  mb = n_ff; end
         F_DEN_B: begin ma = {5'd0, sq_ff};  mb = n_ff; end
         F_W_A:   begin ma = {10'd0, u};     mb = u;    end
         F_W_B:   begin ma = {10'd0, i_ff};  mb = i_ff; end
         F_W_C:   begin ma = {5'd0, u2_ff};  mb = u;    end
         F_W_D:   begin ma = {5'd0, u2_ff};  mb = i_ff; end
         F_W_E:   begin ma = {5'd0, i2_ff};  mb = u;    end
         F_W_F:   begin ma = {5'd0, i2_ff};  mb = i_ff; end
         default: begin ma = '0;             mb = '0;   end
      endcase
   end

   assign mp  = ma * mb;
   assign mp3 = {mp[14:0], 1'b0} + {1'b0, mp[14:0]};

   assign ctl    = ax_ff ? ctl_y_ff[k_ff] : ctl_x_ff[k_ff];
   assign prod   = $signed({1'b0, w_ff[k_ff]}) * ctl;
   assign acc_in = ((k_ff == 2'd0) ? '0 : acc_ff) + {prod[31], prod};

   assign mag = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
   assign dvd = {mag[31:0], 1'b0} + {18'd0, den_ff};

   assign dvs = {den_ff, 1'b0};
   assign r2  = {rem_ff, dq_ff[15]};
   assign ge  = (r2 >= {1'b0, dvs});
   assign res = neg_ff ? -dq_ff : dq_ff;

   assign draw = (cur_x_ff != prev_x_ff) || (cur_y_ff != prev_y_ff);
   assign tail = (i_ff == n_ff);

   assign req_full = (state_ff != F_IDLE);
   assign cq_push  = (state_ff == F_PUSH) && (draw || tail) && !cq_full;
   assign cq_wdata = '{x0: prev_x_ff, y0: prev_y_ff, x1: cur_x_ff, y1: cur_y_ff,
                       draw: draw, tail: tail};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_push) begin
                  ctl_x_ff[0] <= req_p0_x; ctl_y_ff[0] <= req_p0_y;
                  ctl_x_ff[1] <= req_c1_x; ctl_y_ff[1] <= req_c1_y;
                  ctl_x_ff[2] <= req_c2_x; ctl_y_ff[2] <= req_c2_y;
                  ctl_x_ff[3] <= req_p3_x; ctl_y_ff[3] <= req_p3_y;
                  n_ff        <= req_segments;
                  i_ff        <= '0;
                  // no chords: the transaction yields nothing
                  if (req_segments != '0) state_ff <= F_DEN_A;
               end
            end
            F_DEN_A: begin sq_ff  <= mp[9:0];  state_ff <= F_DEN_B; end
            F_DEN_B: begin den_ff <= mp[14:0]; state_ff <= F_W_A;   end
            F_W_A:   begin u2_ff  <= mp[9:0];  state_ff <= F_W_B;   end
            F_W_B:   begin i2_ff  <= mp[9:0];  state_ff <= F_W_C;   end
            F_W_C:   begin w_ff[0] <= mp[14:0];  state_ff <= F_W_D; end
            F_W_D:   begin w_ff[1] <= mp3[14:0]; state_ff <= F_W_E; end
            F_W_E:   begin w_ff[2] <= mp3[14:0]; state_ff <= F_W_F; end
            F_W_F: begin
               w_ff[3]  <= mp[14:0];
               k_ff     <= '0;
               ax_ff    <= 1'b0;
               state_ff <= F_MAC;
            end
            F_MAC: begin
               acc_ff <= acc_in;
               k_ff   <= k_ff + 2'd1;
               if (k_ff == 2'd3) state_ff <= F_PREP;
            end
            F_PREP: begin
               // quotient below 2^16, so the top half starts as remainder
               neg_ff   <= acc_ff[ACC_W-1];
               rem_ff   <= dvd[31:16];
               dq_ff    <= dvd[15:0];
               j_ff     <= '0;
               state_ff <= F_DIV;
            end
            F_DIV: begin
               rem_ff <= ge ? 16'(r2 - {1'b0, dvs}) : r2[15:0];
               dq_ff  <= {dq_ff[14:0], ge};
               j_ff   <= j_ff + 4'd1;
               if (j_ff == 4'd15) state_ff <= F_STORE;
            end
            F_STORE: begin
               if (!ax_ff) begin
                  cur_x_ff <= res;
                  ax_ff    <= 1'b1;
                  k_ff     <= '0;
                  state_ff <= F_MAC;
               end else if (i_ff == '0) begin
                  cur_y_ff  <= res;
                  prev_x_ff <= cur_x_ff;
                  prev_y_ff <= res;
                  i_ff      <= i_ff + 5'd1;
                  state_ff  <= F_W_A;
               end else begin
                  cur_y_ff <= res;
                  state_ff <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (!((draw || tail) && cq_full)) begin
                  prev_x_ff <= cur_x_ff;
                  prev_y_ff <= cur_y_ff;
                  if (tail) begin
                     state_ff <= F_IDLE;
                  end else begin
                     i_ff     <= i_ff + 5'd1;
                     state_ff <= F_W_A;
                  end
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// ----- rtl/cbst_back.sv -----
// ----------------------------------------------------------------------------
// cbst_back
// Widens each chord to a stroke: exact side offsets by a bit-serial search,
// then strip vertices through a one-vertex hold and a four-entry queue.
// ----------------------------------------------------------------------------
module cbst_back import cbst_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               cq_empty,
   input  chord_type          cq_rdata,
   output logic               cq_pop,
   input  logic [WIDTH_W-1:0] stroke_width,
   input  logic [COLOR_W-1:0] fill_color,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output coord_type          rsp_vert_x,
   output coord_type          rsp_vert_y,
   output logic [COLOR_W-1:0] rsp_vert_color,
   output logic               rsp_last
);

   typedef enum logic [3:0] {
      B_IDLE, B_SQ_X, B_SQ_Y, B_MAG, B_TGT, B_TSQ, B_PLO, B_PHI, B_CMP,
      B_OFS, B_EMIT, B_TAIL
   } state_type;

   typedef struct packed {
      coord_type          x;
      coord_type          y;
      logic [COLOR_W-1:0] color;
      logic               last;
   } vertex_type;

   state_type          state_ff;
   chord_type          ch_ff;
   logic [33:0]        s_ff;
   logic               sd_ff;
   logic [27:0]        mag_ff;
   logic [55:0]        tgt_ff;
   logic [11:0]        m_ff;
   logic [3:0]         b_ff;
   logic [23:0]        tsq_ff;
   logic [40:0]        plo_ff, phi_ff;
   logic signed [12:0] xs_ff, ys_ff;
   logic [1:0]         e_ff;
   logic               started_ff;
   logic               hold_valid_ff;
   coord_type          hold_x_ff, hold_y_ff;

   vertex_type         mem [4];
   logic [1:0]         wr_ff, rd_ff;
   logic [2:0]         cnt_ff;

   logic signed [16:0] dx, dy, comp;
   logic signed [33:0] dxsq, dysq;
   logic [16:0]        cabs;
   logic [11:0]        cand, t;
   logic [57:0]        prod;
   logic signed [12:0] mval;
   coord_type          bx, by;
   logic signed [12:0] ox, oy;
   coord_type          vx, vy;
   logic               q_full, push, pop;
   vertex_type         push_data;

   assign dx   = {ch_ff.x1[15], ch_ff.x1} - {ch_ff.x0[15], ch_ff.x0};
   assign dy   = {ch_ff.y1[15], ch_ff.y1} - {ch_ff.y0[15], ch_ff.y0};
   assign dxsq = dx * dx;
   assign dysq = dy * dy;
   assign comp = sd_ff ? dx : dy;
   assign cabs = comp[16] ? -comp : comp;

   assign cand = m_ff | (12'd1 << b_ff);
   assign t    = 12'({cand, 1'b0} - 13'd1);
   assign prod = {17'd0, plo_ff} + {phi_ff, 17'd0};
   assign mval = {1'b0, m_ff};

   assign bx = e_ff[1] ? ch_ff.x1 : ch_ff.x0;
   assign by = e_ff[1] ? ch_ff.y1 : ch_ff.y0;
   assign ox = e_ff[0] ? -xs_ff : xs_ff;
   assign oy = e_ff[0] ? -ys_ff : ys_ff;
   assign vx = sat_coord({{2{bx[15]}}, bx} + {{5{ox[12]}}, ox});
   assign vy = sat_coord({{2{by[15]}}, by} + {{5{oy[12]}}, oy});

   assign q_full    = (cnt_ff == 3'd4);
   assign rsp_empty = (cnt_ff == 3'd0);
   assign pop       = rsp_pop && !rsp_empty;
   assign push      = hold_valid_ff && !q_full &&
                      ((state_ff == B_EMIT) || (state_ff == B_TAIL));
   assign push_data = '{x: hold_x_ff, y: hold_y_ff, color: fill_color,
                        last: (state_ff == B_TAIL)};

   assign rsp_vert_x     = mem[rd_ff].x;
   assign rsp_vert_y     = mem[rd_ff].y;
   assign rsp_vert_color = mem[rd_ff].color;
   assign rsp_last       = mem[rd_ff].last;

   assign cq_pop = (state_ff == B_IDLE) && !cq_empty;

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop)  rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(push ? 1 : 0) - 3'(pop ? 1 : 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         started_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            B_IDLE: begin
               if (!cq_empty) begin
                  ch_ff    <= cq_rdata;
                  sd_ff    <= 1'b0;
                  state_ff <= cq_rdata.draw ? B_SQ_X : B_TAIL;
               end
            end
            B_SQ_X: begin s_ff <= dxsq[33:0]; state_ff <= B_SQ_Y; end
            B_SQ_Y: begin s_ff <= s_ff + dysq[33:0]; state_ff <= B_MAG; end
            B_MAG: begin
               mag_ff   <= cabs[15:0] * stroke_width;
               m_ff     <= '0;
               b_ff     <= 4'd11;
               state_ff <= B_TGT;
            end
            B_TGT: begin tgt_ff <= mag_ff * mag_ff; state_ff <= B_TSQ; end
            B_TSQ: begin
               // offsets never exceed 2048
               if (cand > 12'd2048) begin
                  b_ff     <= b_ff - 4'd1;
                  state_ff <= (b_ff == 4'd0) ? B_OFS : B_TSQ;
               end else begin
                  tsq_ff   <= t * t;
                  state_ff <= B_PLO;
               end
            end
            B_PLO: begin plo_ff <= tsq_ff * s_ff[16:0];  state_ff <= B_PHI; end
            B_PHI: begin phi_ff <= tsq_ff * s_ff[33:17]; state_ff <= B_CMP; end
            B_CMP: begin
               if (prod <= {2'd0, tgt_ff}) m_ff <= cand;
               b_ff     <= b_ff - 4'd1;
               state_ff <= (b_ff == 4'd0) ? B_OFS : B_TSQ;
            end
            B_OFS: begin
               if (!sd_ff) begin
                  xs_ff    <= comp[16] ? -mval : mval;
                  sd_ff    <= 1'b1;
                  state_ff <= B_MAG;
               end else begin
                  ys_ff    <= comp[16] ? mval : -mval;
                  e_ff     <= started_ff ? 2'd2 : 2'd0;
                  state_ff <= B_EMIT;
               end
            end
            B_EMIT: begin
               if (!(hold_valid_ff && q_full)) begin
                  hold_x_ff     <= vx;
                  hold_y_ff     <= vy;
                  hold_valid_ff <= 1'b1;
                  e_ff          <= e_ff + 2'd1;
                  if (e_ff == 2'd3) begin
                     started_ff <= 1'b1;
                     state_ff   <= ch_ff.tail ? B_TAIL : B_IDLE;
                  end
               end
            end
            B_TAIL: begin
               // held vertex is the curve's final one
               if (!(hold_valid_ff && q_full)) begin
                  hold_valid_ff <= 1'b0;
                  started_ff    <= 1'b0;
                  state_ff      <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

// ----- rtl/cubic_bezier_stroke_tessellator_top.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_stroke_tessellator_top
// Flattens a cubic Bezier into chords and emits a stroked triangle strip.
// ----------------------------------------------------------------------------
// Input channel (req_): one transaction carries four control points in
// signed Q12.4 and a chord count n. It is taken when req_push is high and
// req_full is low. For a nonzero n the front part then holds req_full high
// while it works out the n+1 curve points, rounding each coordinate through
// a 16-step divider.
// Result channel (rsp_): strip vertices in order; the head of the queue is
// on the rsp_ ports while rsp_empty is low and leaves when rsp_pop is high.
// Each non-degenerate chord occupies the back part for the bit-serial offset
// search (twelve trial steps, each trial not above 2048 through a 24x17
// multiplier twice, for each of the two offsets). The front runs ahead by
// up to four chords while the back part works.
// A stalled receiver fills the four-entry vertex queue, then the chord
// queue, then holds req_full high; nothing is dropped.
// Configuration (csr_): csr_ready is always high; write only when idle.
// Reset (synchronous, active high) empties both queues, aborts any curve in
// flight and restores a stroke width of 3.0 pixels and a zero fill colour.
// ----------------------------------------------------------------------------
module cubic_bezier_stroke_tessellator_top import cbst_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  coord_type            req_p0_x,
   input  coord_type            req_p0_y,
   input  coord_type            req_c1_x,
   input  coord_type            req_c1_y,
   input  coord_type            req_c2_x,
   input  coord_type            req_c2_y,
   input  coord_type            req_p3_x,
   input  coord_type            req_p3_y,
   input  logic [SEG_W-1:0]     req_segments,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output coord_type            rsp_vert_x,
   output coord_type            rsp_vert_y,
   output logic [COLOR_W-1:0]   rsp_vert_color,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_data
);

   logic [WIDTH_W-1:0] stroke_width_ff;
   logic [COLOR_W-1:0] fill_color_ff;

   logic      cq_push, cq_full, cq_pop, cq_empty;
   chord_type cq_wdata, cq_rdata;

   assign csr_ready = 1'b1;

   // register file; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         stroke_width_ff <= STROKE_WIDTH_RESET;
         fill_color_ff   <= FILL_COLOR_RESET;
      end else if (csr_valid) begin
         priority case (csr_index)
            CSR_STROKE_WIDTH: stroke_width_ff <= csr_data[WIDTH_W-1:0];
            CSR_FILL_COLOR:   fill_color_ff   <= csr_data;
            default:          ;
         endcase
      end
   end

   cbst_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_p0_x     (req_p0_x),
      .req_p0_y     (req_p0_y),
      .req_c1_x     (req_c1_x),
      .req_c1_y     (req_c1_y),
      .req_c2_x     (req_c2_x),
      .req_c2_y     (req_c2_y),
      .req_p3_x     (req_p3_x),
      .req_p3_y     (req_p3_y),
      .req_segments (req_segments),
      .cq_push      (cq_push),
      .cq_wdata     (cq_wdata),
      .cq_full      (cq_full)
   );

   cbst_chord_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .cq_push  (cq_push),
      .cq_wdata (cq_wdata),
      .cq_full  (cq_full),
      .cq_pop   (cq_pop),
      .cq_rdata (cq_rdata),
      .cq_empty (cq_empty)
   );

   cbst_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cq_empty       (cq_empty),
      .cq_rdata       (cq_rdata),
      .cq_pop         (cq_pop),
      .stroke_width   (stroke_width_ff),
      .fill_color     (fill_color_ff),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_vert_x     (rsp_vert_x),
      .rsp_vert_y     (rsp_vert_y),
      .rsp_vert_color (rsp_vert_color),
      .rsp_last       (rsp_last)
   );

endmodule
